// ----- rtl/imc_pkg.sv -----
// Shared types, widths and constants of the IMU motion classifier.
package imc_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 16;

    // Weights (lpf_weight, time_step) are always Q16.
    localparam int WEIGHT_W   = 17;
    localparam int WEIGHT_ONE = 65536;
    localparam int Q16_SHIFT  = 16;
    localparam int ROUND_HALF = 32768;
    localparam int BAND_W     = 23;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = 2;
    localparam int AXIS_LAST = NUM_AXES - 1;

    // Sum of three squares fits 2*SAMPLE_BITS; its root fits SAMPLE_BITS.
    localparam int ROOT_W = SAMPLE_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ACC_W  = WEIGHT_W + ROOT_W + 1;

    // Signed time step times yaw rate; also wide enough for the heading sum.
    localparam int PROD_W = WEIGHT_W + 1 + SAMPLE_BITS;

    localparam int WIDE_BITS = (SAMPLE_BITS > FRACTION_BITS) ? SAMPLE_BITS : FRACTION_BITS;
    localparam int CMP_W     = ((WIDE_BITS > BAND_W) ? WIDE_BITS : BAND_W) + 3;

    localparam int CNT_W     = $clog2(SAMPLE_BITS);
    localparam int ROOT_LAST = ROOT_W - 1;

    // Heading word: heading * WORD_SCALE / 2^(16 + FRACTION_BITS), toward zero.
    localparam int WORD_SCALE = 341772207;
    localparam int SCALE_W    = 30;
    localparam int HEAD_W     = 32;
    localparam int WPROD_W    = HEAD_W + SCALE_W;
    localparam int WSHIFT     = 16 + FRACTION_BITS;
    localparam int WORD_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LPF_WEIGHT       = 3'd0,
        CFG_STILL_ACCEL_BAND = 3'd1,
        CFG_STILL_GYRO_BAND  = 3'd2,
        CFG_CURVE_RATE       = 3'd3,
        CFG_SLOPE_BAND       = 3'd4,
        CFG_TIME_STEP        = 3'd5
    } t_cfg_idx;

    localparam int OP_SAMPLE      = 0;
    localparam int OP_SET_HEADING = 1;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] slow_gyro_x;
        logic signed [SAMPLE_BITS-1:0] slow_gyro_y;
        logic signed [SAMPLE_BITS-1:0] slow_gyro_z;
        logic signed [HEAD_W-1:0]      new_heading;
    } t_in;

    typedef struct packed {
        logic                     stopped;
        logic                     curving;
        logic                     on_slope;
        logic signed [HEAD_W-1:0] heading_rad;
        logic signed [WORD_W-1:0] heading_word;
    } t_out;

    // Configuration as seen by the datapath, weights already clamped to one.
    typedef struct packed {
        logic [WEIGHT_W-1:0] lpf_weight;
        logic [BAND_W-1:0]   still_accel_band;
        logic [BAND_W-1:0]   still_gyro_band;
        logic [BAND_W-1:0]   curve_rate;
        logic [BAND_W-1:0]   slope_band;
        logic [WEIGHT_W-1:0] time_step;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic              sq_step;
        logic [AXIS_W-1:0] sq_idx;
        logic              root_step;
        logic              avg_a;
        logic              avg_b;
        logic              eval;
        logic              head;
        logic              word;
        logic              out_load;
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_AVG_A,
        S_AVG_B,
        S_EVAL,
        S_HEAD,
        S_WORD,
        S_DONE
    } t_state;

endpackage

// ----- rtl/imu_motion_classifier.sv -----
// Top level of the IMU motion classifier and heading integrator.
//
// Input channel (i_in_valid / o_in_ready, payload i_in): one item per transfer,
// either a sensor sample or a set-heading command (op). Output channel
// (o_out_valid / i_out_ready, payload o_out): exactly one result per item,
// carrying the stopped, curving and slope flags, the heading and the 16-bit
// heading word. Configuration channel (i_cfg_valid / o_cfg_ready) writes one
// register per transfer; write only while the block is idle.
//
// A sample passes from its transfer to o_out_valid through the squares of
// the three axes on one multiplier, the shift-subtract square root at one
// root bit per cycle, then the average, flags, heading and word steps. A
// set-heading item goes straight to the word step. The next item can be taken
// in the cycle after the result is loaded, so the block takes no new item
// while one is in progress.
// The result sits in an output register; while the receiver stalls, the block
// finishes the next item and waits with it until the register is taken.
// Reset (synchronous, active low) clears heading, norm average and flags and
// loads the default configuration.
module imu_motion_classifier import imc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    imc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    imc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    imc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/imc_cfg.sv -----
// Configuration register file with weight clamping.
module imc_cfg import imc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [WEIGHT_W-1:0] r_lpf_weight;
    logic [BAND_W-1:0]   r_still_accel_band;
    logic [BAND_W-1:0]   r_still_gyro_band;
    logic [BAND_W-1:0]   r_curve_rate;
    logic [BAND_W-1:0]   r_slope_band;
    logic [WEIGHT_W-1:0] r_time_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpf_weight       <= WEIGHT_W'(655);
            r_still_accel_band <= BAND_W'(1311);
            r_still_gyro_band  <= BAND_W'(343);
            r_curve_rate       <= BAND_W'(114368);
            r_slope_band       <= BAND_W'(6554);
            r_time_step        <= WEIGHT_W'(655);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LPF_WEIGHT:       r_lpf_weight       <= i_cfg_data[WEIGHT_W-1:0];
                CFG_STILL_ACCEL_BAND: r_still_accel_band <= i_cfg_data[BAND_W-1:0];
                CFG_STILL_GYRO_BAND:  r_still_gyro_band  <= i_cfg_data[BAND_W-1:0];
                CFG_CURVE_RATE:       r_curve_rate       <= i_cfg_data[BAND_W-1:0];
                CFG_SLOPE_BAND:       r_slope_band       <= i_cfg_data[BAND_W-1:0];
                CFG_TIME_STEP:        r_time_step        <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Weights above one act as one.
    always_comb begin
        o_cfg.lpf_weight       = (r_lpf_weight > WEIGHT_W'(WEIGHT_ONE))
                               ? WEIGHT_W'(WEIGHT_ONE) : r_lpf_weight;
        o_cfg.time_step        = (r_time_step > WEIGHT_W'(WEIGHT_ONE))
                               ? WEIGHT_W'(WEIGHT_ONE) : r_time_step;
        o_cfg.still_accel_band = r_still_accel_band;
        o_cfg.still_gyro_band  = r_still_gyro_band;
        o_cfg.curve_rate       = r_curve_rate;
        o_cfg.slope_band       = r_slope_band;
    end

endmodule

// ----- rtl/imc_datapath.sv -----
// Datapath: squares, bit-serial square root, norm average, flags, heading, heading word.
module imc_datapath import imc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in,
    input  t_dp_cmd i_cmd,
    input  t_cfg    i_cfg,
    output t_out    o_out
);

    localparam logic signed [SCALE_W-1:0] SCALE_S = SCALE_W'(WORD_SCALE);

    logic signed [SAMPLE_BITS-1:0] r_g [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_a [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_s [NUM_AXES];

    logic [SQ_W-1:0]   r_sum;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ACC_W-1:0]  r_acc;

    logic signed [PROD_W-1:0]  r_inc_prod;
    logic signed [WPROD_W-1:0] r_wprod;
    logic                      r_still_z;

    logic signed [HEAD_W-1:0] r_heading;
    logic [ROOT_W-1:0]        r_avg;
    logic                     r_stop;
    logic                     r_curve;
    logic                     r_slope;

    t_out r_out;

    function automatic logic [CMP_W-1:0] f_mag(input logic signed [CMP_W-1:0] v);
        return v[CMP_W-1] ? CMP_W'(-v) : CMP_W'(v);
    endfunction

    // Squares
    logic signed [SAMPLE_BITS-1:0] a_sel;
    logic [SAMPLE_BITS-1:0]        a_mag;
    logic [SQ_W-1:0]               sq;

    always_comb begin
        a_sel = r_a[i_cmd.sq_idx];
        a_mag = a_sel[SAMPLE_BITS-1] ? SAMPLE_BITS'(-a_sel) : SAMPLE_BITS'(a_sel);
        sq    = SQ_W'(a_mag * a_mag);
    end

    // Square root, two bits of the radicand per step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_sum[SQ_W-1 -: 2]};
        trial  = {r_root, 2'b01};
    end

    // Evaluation
    logic [ROOT_W-1:0]         avg_new;
    logic signed [CMP_W-1:0]   nd;
    logic                      norm_ok;
    logic [NUM_AXES-1:0]       axis_still;
    logic signed [CMP_W-1:0]   gdiff [NUM_AXES];
    logic signed [CMP_W-1:0]   gz_eff;
    logic signed [CMP_W-1:0]   slope_d;
    logic                      stopped;
    logic signed [WEIGHT_W:0]  ts_s;
    logic [WEIGHT_W-1:0]       w_inv;

    always_comb begin
        avg_new = r_acc[Q16_SHIFT +: ROOT_W];
        nd      = signed'(CMP_W'(avg_new)) - signed'(CMP_W'(r_root));
        norm_ok = f_mag(nd) < CMP_W'(i_cfg.still_accel_band);
        for (int i = 0; i < NUM_AXES; i++) begin
            gdiff[i]      = CMP_W'(r_s[i]) - CMP_W'(r_g[i]);
            axis_still[i] = norm_ok && (f_mag(gdiff[i]) < CMP_W'(i_cfg.still_gyro_band));
        end
        stopped = &axis_still;
        gz_eff  = axis_still[AXIS_LAST] ? '0 : CMP_W'(r_g[AXIS_LAST]);
        slope_d = signed'(CMP_W'(1 << FRACTION_BITS))
                - signed'(f_mag(CMP_W'(r_a[AXIS_LAST])));
        ts_s    = signed'({1'b0, i_cfg.time_step});
        w_inv   = WEIGHT_W'(WEIGHT_ONE) - i_cfg.lpf_weight;
    end

    // Heading update with saturation
    logic signed [PROD_W-1:0]   inc_full;
    logic signed [PROD_W-1:0]   h_sum;
    logic [PROD_W-HEAD_W:0]     h_upper;
    logic signed [HEAD_W-1:0]   h_sat;

    always_comb begin
        inc_full = r_inc_prod + PROD_W'(ROUND_HALF);
        h_sum    = PROD_W'(r_heading) + (r_still_z ? PROD_W'(0) : (inc_full >>> Q16_SHIFT));
        h_upper  = h_sum[PROD_W-1:HEAD_W-1];
        if ((&h_upper) || !(|h_upper)) begin
            h_sat = h_sum[HEAD_W-1:0];
        end else if (h_sum[PROD_W-1]) begin
            h_sat = {1'b1, {(HEAD_W-1){1'b0}}};
        end else begin
            h_sat = {1'b0, {(HEAD_W-1){1'b1}}};
        end
    end

    // Heading word, truncated toward zero
    logic signed [WPROD_W-1:0] wq;

    always_comb begin
        wq = r_wprod >>> WSHIFT;
        if (r_wprod[WPROD_W-1] && (|r_wprod[WSHIFT-1:0])) begin
            wq = wq + WPROD_W'(1);
        end
    end

    // Item registers and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_g[0] <= i_in.gyro_x;
            r_g[1] <= i_in.gyro_y;
            r_g[2] <= i_in.gyro_z;
            r_a[0] <= i_in.accel_x;
            r_a[1] <= i_in.accel_y;
            r_a[2] <= i_in.accel_z;
            r_s[0] <= i_in.slow_gyro_x;
            r_s[1] <= i_in.slow_gyro_y;
            r_s[2] <= i_in.slow_gyro_z;
            r_sum  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sum <= r_sum + sq;
        end else if (i_cmd.root_step) begin
            r_sum <= r_sum << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end

        if (i_cmd.avg_a) begin
            r_acc <= ACC_W'(i_cfg.lpf_weight * r_avg);
        end else if (i_cmd.avg_b) begin
            r_acc <= r_acc + ACC_W'(w_inv * r_root) + ACC_W'(ROUND_HALF);
        end

        if (i_cmd.eval) begin
            r_inc_prod <= PROD_W'(ts_s * r_g[AXIS_LAST]);
            r_still_z  <= axis_still[AXIS_LAST];
        end

        if (i_cmd.word) begin
            r_wprod <= WPROD_W'(r_heading * SCALE_S);
        end

        if (i_cmd.out_load) begin
            r_out.stopped      <= r_stop;
            r_out.curving      <= r_curve;
            r_out.on_slope     <= r_slope;
            r_out.heading_rad  <= r_heading;
            r_out.heading_word <= wq[WORD_W-1:0];
        end
    end

    // Persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_avg     <= '0;
            r_stop    <= 1'b0;
            r_curve   <= 1'b0;
            r_slope   <= 1'b0;
        end else begin
            if (i_cmd.load && i_in.op) begin
                r_heading <= i_in.new_heading;
            end else if (i_cmd.head && !r_stop) begin
                r_heading <= h_sat;
            end
            if (i_cmd.eval) begin
                r_avg   <= avg_new;
                r_stop  <= stopped;
                r_curve <= f_mag(gz_eff) > CMP_W'(i_cfg.curve_rate);
                r_slope <= f_mag(slope_d) > CMP_W'(i_cfg.slope_band);
            end
        end
    end

    assign o_out = r_out;

endmodule

// ----- rtl/imc_ctrl.sv -----
// Sequencer that steps the datapath through one item and owns the input and output handshakes.
module imc_ctrl import imc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = (i_in_op == 1'(OP_SET_HEADING)) ? S_WORD : S_SQ;
                end
            end
            S_SQ: begin
                if (r_cnt == CNT_W'(AXIS_LAST)) begin
                    n_state = S_ROOT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_ROOT: begin
                if (r_cnt == CNT_W'(ROOT_LAST)) begin
                    n_state = S_AVG_A;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_AVG_A: n_state = S_AVG_B;
            S_AVG_B: n_state = S_EVAL;
            S_EVAL:  n_state = S_HEAD;
            S_HEAD:  n_state = S_WORD;
            S_WORD:  n_state = S_DONE;
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                o_cmd.sq_idx  = r_cnt[AXIS_W-1:0];
            end
            S_ROOT:  o_cmd.root_step = 1'b1;
            S_AVG_A: o_cmd.avg_a     = 1'b1;
            S_AVG_B: o_cmd.avg_b     = 1'b1;
            S_EVAL:  o_cmd.eval      = 1'b1;
            S_HEAD:  o_cmd.head      = 1'b1;
            S_WORD:  o_cmd.word      = 1'b1;
            S_DONE:  o_cmd.out_load  = slot_free;
            default: ;
        endcase
    end

    // Hold the result until its transfer; a new result may replace a taken one.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_set_heading_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_op) |=> (r_state == S_WORD))
        else $error("set-heading item did not go straight to the word multiply");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_op) |=> (r_state == S_SQ && r_cnt == '0))
        else $error("sample item did not start the squares at axis zero");

    a_root_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && r_cnt == CNT_W'(ROOT_LAST)) |=> (r_state == S_AVG_A))
        else $error("square root ran past its last digit");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

// ----- dv/imc_classify_check.sv -----
// Result predictor and checker for the IMU motion classifier bench.
module imc_classify_check import imc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_open_count
);

    localparam longint HEAD_MAX = 64'sd2147483647;
    localparam longint HEAD_MIN = -HEAD_MAX - 1;

    // Register values after reset.
    localparam longint RST_LPF_WEIGHT  = 655;
    localparam longint RST_ACCEL_BAND  = 1311;
    localparam longint RST_GYRO_BAND   = 343;
    localparam longint RST_CURVE_RATE  = 114368;
    localparam longint RST_SLOPE_BAND  = 6554;
    localparam longint RST_TIME_STEP   = 655;

    longint lpf_weight;
    longint accel_band;
    longint gyro_band;
    longint curve_limit;
    longint slope_limit;
    longint time_step;

    logic signed [HEAD_W-1:0] heading;
    longint                   norm_avg;
    logic                     stop_flag;
    logic                     curve_flag;
    logic                     slope_flag;

    t_out classified_q [$];
    int   fail_count;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the mirrored state by one item and return the result it yields.
    function automatic t_out classify_item(input t_in x);
        longint gyro  [NUM_AXES];
        longint slow  [NUM_AXES];
        longint accel [NUM_AXES];
        longint sq_sum;
        longint root;
        longint trial;
        longint w;
        longint ts;
        longint next_head;
        longint word;
        int     n_still;
        t_out   res;
        if (x.op == 1'(OP_SET_HEADING)) begin
            heading = x.new_heading;
        end else begin
            gyro[0]  = longint'(x.gyro_x);
            gyro[1]  = longint'(x.gyro_y);
            gyro[2]  = longint'(x.gyro_z);
            accel[0] = longint'(x.accel_x);
            accel[1] = longint'(x.accel_y);
            accel[2] = longint'(x.accel_z);
            slow[0]  = longint'(x.slow_gyro_x);
            slow[1]  = longint'(x.slow_gyro_y);
            slow[2]  = longint'(x.slow_gyro_z);

            sq_sum = 0;
            for (int k = 0; k < NUM_AXES; k++) begin
                sq_sum += accel[k] * accel[k];
            end
            // floor square root, one bit at a time from the top
            root = 0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root + (longint'(1) << b);
                if (trial * trial <= sq_sum) begin
                    root = trial;
                end
            end

            w = (lpf_weight > WEIGHT_ONE) ? WEIGHT_ONE : lpf_weight;
            norm_avg = (w * norm_avg + (WEIGHT_ONE - w) * root + ROUND_HALF) >>> Q16_SHIFT;

            n_still = 0;
            if (magnitude(norm_avg - root) < accel_band) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (magnitude(slow[k] - gyro[k]) < gyro_band) begin
                        gyro[k] = 0;
                        n_still++;
                    end
                end
            end
            stop_flag  = (n_still == NUM_AXES);
            curve_flag = magnitude(gyro[AXIS_LAST]) > curve_limit;
            slope_flag = magnitude((longint'(1) << FRACTION_BITS) - magnitude(accel[AXIS_LAST]))
                         > slope_limit;

            if (!stop_flag) begin
                ts = (time_step > WEIGHT_ONE) ? WEIGHT_ONE : time_step;
                next_head = longint'(heading)
                            + ((ts * gyro[AXIS_LAST] + ROUND_HALF) >>> Q16_SHIFT);
                if (next_head > HEAD_MAX) begin
                    next_head = HEAD_MAX;
                end
                if (next_head < HEAD_MIN) begin
                    next_head = HEAD_MIN;
                end
                heading = HEAD_W'(next_head);
            end
        end
        // scale toward zero, then keep the low word
        word = (longint'(heading) * WORD_SCALE) / (longint'(1) << WSHIFT);
        res.stopped      = stop_flag;
        res.curving      = curve_flag;
        res.on_slope     = slope_flag;
        res.heading_rad  = heading;
        res.heading_word = WORD_W'(word);
        return res;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            lpf_weight  = RST_LPF_WEIGHT;
            accel_band  = RST_ACCEL_BAND;
            gyro_band   = RST_GYRO_BAND;
            curve_limit = RST_CURVE_RATE;
            slope_limit = RST_SLOPE_BAND;
            time_step   = RST_TIME_STEP;
            heading     = '0;
            norm_avg    = 0;
            stop_flag   = 1'b0;
            curve_flag  = 1'b0;
            slope_flag  = 1'b0;
            fail_count  = 0;
            classified_q.delete();
        end else begin
            // check the outgoing transfer first: it always belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (classified_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: stray result, expected none, actual %h", $time, i_out);
                end else begin
                    want = classified_q.pop_front();
                    compare_field("stopped", longint'(want.stopped),
                                  longint'(i_out.stopped));
                    compare_field("curving", longint'(want.curving),
                                  longint'(i_out.curving));
                    compare_field("on_slope", longint'(want.on_slope),
                                  longint'(i_out.on_slope));
                    compare_field("heading_rad", longint'(want.heading_rad),
                                  longint'(i_out.heading_rad));
                    compare_field("heading_word", longint'(want.heading_word),
                                  longint'(i_out.heading_word));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LPF_WEIGHT:       lpf_weight  = longint'(i_cfg_data[WEIGHT_W-1:0]);
                    CFG_STILL_ACCEL_BAND: accel_band  = longint'(i_cfg_data[BAND_W-1:0]);
                    CFG_STILL_GYRO_BAND:  gyro_band   = longint'(i_cfg_data[BAND_W-1:0]);
                    CFG_CURVE_RATE:       curve_limit = longint'(i_cfg_data[BAND_W-1:0]);
                    CFG_SLOPE_BAND:       slope_limit = longint'(i_cfg_data[BAND_W-1:0]);
                    CFG_TIME_STEP:        time_step   = longint'(i_cfg_data[WEIGHT_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                classified_q.push_back(classify_item(i_in));
            end
        end
        o_fail_count <= fail_count;
        o_open_count <= classified_q.size();
    end

endmodule

// ----- dv/imu_motion_classifier_test.sv -----
// Stimulus, clocking and verdict for the IMU motion classifier bench.
module imu_motion_classifier_test;
    import imc_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 80;
    localparam int NUM_REGS    = 6;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    open_count;
    int                    quiet     = 0;
    bit                    idling    = 1'b1;
    bit                    stall_req = 1'b0;

    imu_motion_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    imc_classify_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    always #5 clk = ~clk;

    function automatic int spread(input int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    function automatic t_in mk_sample(input int gx, input int gy, input int gz,
                                      input int ax, input int ay, input int az,
                                      input int sx, input int sy, input int sz);
        t_in it;
        it = '0;
        it.op          = 1'(OP_SAMPLE);
        it.gyro_x      = SAMPLE_BITS'(gx);
        it.gyro_y      = SAMPLE_BITS'(gy);
        it.gyro_z      = SAMPLE_BITS'(gz);
        it.accel_x     = SAMPLE_BITS'(ax);
        it.accel_y     = SAMPLE_BITS'(ay);
        it.accel_z     = SAMPLE_BITS'(az);
        it.slow_gyro_x = SAMPLE_BITS'(sx);
        it.slow_gyro_y = SAMPLE_BITS'(sy);
        it.slow_gyro_z = SAMPLE_BITS'(sz);
        return it;
    endfunction

    function automatic t_in mk_heading(input int h);
        t_in it;
        it = '0;
        it.op          = 1'(OP_SET_HEADING);
        it.new_heading = h;
        return it;
    endfunction

    // Mostly plausible motion around one g, plus raw noise and heading loads.
    function automatic t_in rand_item();
        t_in it;
        int  kind;
        int  amp;
        bit  at_rest;
        kind = $urandom_range(0, 99);
        it.op          = 1'(OP_SAMPLE);
        it.gyro_x      = 24'($urandom);
        it.gyro_y      = 24'($urandom);
        it.gyro_z      = 24'($urandom);
        it.accel_x     = 24'($urandom);
        it.accel_y     = 24'($urandom);
        it.accel_z     = 24'($urandom);
        it.slow_gyro_x = 24'($urandom);
        it.slow_gyro_y = 24'($urandom);
        it.slow_gyro_z = 24'($urandom);
        it.new_heading = $urandom;
        if (kind < 10) begin
            it.op = 1'(OP_SET_HEADING);
            if (kind == 0) begin
                it.new_heading = 32'h7FFF_FFFF - $urandom_range(0, 100000);
            end else if (kind == 1) begin
                it.new_heading = 32'h8000_0000 + $urandom_range(0, 100000);
            end
        end else if (kind >= 22) begin
            at_rest = ($urandom_range(0, 2) == 0);
            amp = ($urandom_range(0, 3) == 0) ? 30000 : 3000;
            it.accel_x = SAMPLE_BITS'(spread(3000));
            it.accel_y = SAMPLE_BITS'(spread(3000));
            it.accel_z = SAMPLE_BITS'(($urandom_range(0, 1) ? 65536 : -65536) + spread(amp));
            it.slow_gyro_x = SAMPLE_BITS'(spread(200000));
            it.slow_gyro_y = SAMPLE_BITS'(spread(200000));
            it.slow_gyro_z = SAMPLE_BITS'(spread(200000));
            it.gyro_x = SAMPLE_BITS'(it.slow_gyro_x + (at_rest ? spread(300)
                        : ($urandom_range(0, 3) != 0) ? spread(600) : spread(300000)));
            it.gyro_y = SAMPLE_BITS'(it.slow_gyro_y + (at_rest ? spread(300)
                        : ($urandom_range(0, 3) != 0) ? spread(600) : spread(300000)));
            it.gyro_z = SAMPLE_BITS'(it.slow_gyro_z + (at_rest ? spread(300)
                        : ($urandom_range(0, 3) != 0) ? spread(600) : spread(300000)));
        end
        return it;
    endfunction

    task automatic send_item(input t_in item);
        if (idling && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (open_count != 0);
    endtask

    task automatic set_config(input int lpf, input int accel_band, input int gyro_band,
                              input int curve, input int slope, input int tstep);
        t_cfg_idx              order [NUM_REGS];
        logic [CFG_DATA_W-1:0] value [NUM_REGS];
        order = '{CFG_LPF_WEIGHT, CFG_STILL_ACCEL_BAND, CFG_STILL_GYRO_BAND,
                  CFG_CURVE_RATE, CFG_SLOPE_BAND, CFG_TIME_STEP};
        value = '{CFG_DATA_W'(lpf), CFG_DATA_W'(accel_band), CFG_DATA_W'(gyro_band),
                  CFG_DATA_W'(curve), CFG_DATA_W'(slope), CFG_DATA_W'(tstep)};
        for (int k = 0; k < NUM_REGS; k++) begin
            cfg_index <= order[k];
            cfg_data  <= value[k];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                stall_req = 1'b1;
            end
            if (n == pause_at) begin
                wait_results();
            end
            send_item(rand_item());
        end
    endtask

    // Result-side ready: random stall bursts, long hold on request.
    initial begin
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idling && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // End the run if no transfer happens on any channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("[imu_motion_classifier] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration
        send_item(mk_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_sample(100, -100, 50, 0, 0, 65536, 0, 0, 0));
        send_item(mk_sample(0, 0, 200000, 1000, -1000, 65536, 0, 0, 0));
        send_item(mk_sample(0, 0, -200000, 0, 0, -65536, 0, 0, 0));
        send_item(mk_sample(0, 0, 114368, 0, 0, 65536 + 6554, 0, 0, 0));
        send_item(mk_sample(0, 0, 114369, 0, 0, 65536 + 6555, 0, 0, 0));
        send_item(mk_sample(0, 0, 0, 8388607, 8388607, 8388607, 0, 0, 0));
        send_item(mk_sample(0, 0, 0, -8388608, -8388608, -8388608, 0, 0, 0));
        send_item(mk_sample(8388607, 8388607, 8388607, 0, 0, 65536,
                            -8388608, -8388608, -8388608));
        send_item(mk_sample(-8388608, -8388608, -8388608, 0, 0, 65536,
                            8388607, 8388607, 8388607));
        // saturate the heading at both ends
        send_item(mk_heading(32'h7FFF_FFFF));
        send_item(mk_sample(0, 0, 8388607, 0, 0, 65536, 0, 0, 0));
        send_item(mk_heading(32'h8000_0000));
        send_item(mk_sample(0, 0, -8388608, 0, 0, 65536, 0, 0, 0));
        // one and two turns, so the heading word wraps
        send_item(mk_heading(411775));
        send_item(mk_heading(823550));
        send_item(mk_heading(-823550));
        send_item(mk_heading(-1));
        send_item(mk_sample(20, -20, 5000, 0, 0, 65536, 0, 0, 0));
        send_item(mk_sample(0, 0, 300, 0, 0, 65536, 0, 0, 0));
        send_item(mk_heading(12345));
        // sudden norm change: gyros close but nothing is zeroed
        send_item(mk_sample(10, 10, 5000, 0, 0, 200000, 0, 0, 5000));
        wait_results();

        set_config(655, 1311, 343, 114368, 6554, 655);
        run_random(500, 120, 320);
        wait_results();

        // weights above one, widest bands
        set_config(131071, 8388607, 8388607, 8388607, 8388607, 131071);
        run_random(200, -1, -1);
        wait_results();

        set_config(0, 0, 0, 0, 0, 0);
        run_random(150, 60, -1);
        wait_results();

        set_config(65536, 2000, 500, 100000, 8000, 65536);
        run_random(300, -1, 150);
        wait_results();

        idling = 1'b0;
        for (int c = 0; c < 5; c++) begin
            set_config($urandom_range(0, 131071), $urandom_range(0, 20000),
                       $urandom_range(0, 4000), $urandom_range(0, 400000),
                       $urandom_range(0, 30000), $urandom_range(0, 131071));
            run_random(100, -1, -1);
            wait_results();
        end

        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("[imu_motion_classifier] OK");
        end else begin
            $display("[imu_motion_classifier] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/imc_pkg.sv
rtl/imc_cfg.sv
rtl/imc_datapath.sv
rtl/imc_ctrl.sv
rtl/imu_motion_classifier.sv
dv/imc_classify_check.sv
dv/imu_motion_classifier_test.sv
